>>> rtl/fcfp_pkg.sv
// Shared constants for the flight command frame parser.
// No dependencies.
package fcfp_pkg;

  // Frame header bytes
  localparam logic [7:0] HDR_FIRST  = 8'hBB;
  localparam logic [7:0] HDR_SECOND = 8'hE1;

  // Type byte codes
  localparam logic [7:0] TYPE_SET = 8'd1;
  localparam logic [7:0] TYPE_HGT = 8'd2;
  localparam logic [7:0] TYPE_FLY = 8'd3;

  // Frame kind reported on out_tuser
  localparam logic [1:0] KIND_SET = 2'd0;
  localparam logic [1:0] KIND_HGT = 2'd1;
  localparam logic [1:0] KIND_FLY = 2'd2;

  // Setting codes
  localparam logic [7:0] SET_DISARM    = 8'd1;
  localparam logic [7:0] SET_ARM       = 8'd2;
  localparam logic [7:0] SET_MOTOR_OFF = 8'd3;

  // Height command codes and the modes they select
  localparam logic [7:0] HCMD_TARGET = 8'd1;
  localparam logic [7:0] HCMD_MODE4  = 8'd2;
  localparam logic [7:0] HCMD_MODE3  = 8'd3;
  localparam logic [7:0] HCMD_MODE1  = 8'd4;
  localparam logic [2:0] HMODE_TARGET = 3'd5;
  localparam logic [2:0] HMODE_4      = 3'd4;
  localparam logic [2:0] HMODE_3      = 3'd3;
  localparam logic [2:0] HMODE_1      = 3'd1;

  // Flight command codes and the modes they select
  localparam logic [7:0] FCMD_1 = 8'd1;
  localparam logic [7:0] FCMD_2 = 8'd2;
  localparam logic [7:0] FCMD_3 = 8'd3;
  localparam logic [7:0] FCMD_4 = 8'd4;
  localparam logic [7:0] FCMD_5 = 8'd5;
  localparam logic [2:0] FMODE_1 = 3'd3;
  localparam logic [2:0] FMODE_2 = 3'd4;
  localparam logic [2:0] FMODE_3 = 3'd6;
  localparam logic [2:0] FMODE_4 = 3'd5;
  localparam logic [2:0] FMODE_5 = 3'd1;

  localparam logic [11:0] MAX_HEIGHT = 12'd2550;

endpackage

>>> rtl/flight_command_frame_parser.sv
// Bytes enter the input register; a frame's last byte fills the result register.
// Throughput: one byte per cycle; in_tready drops only while both the input
// register and the result register are full and out_tready is low.
// Reset: rst_n synchronous, active low; parser hunts for 0xBB, armed = 0,
// motor_enable = 1, height/flight modes and target height = 0, no result pending.
module flight_command_frame_parser
  import fcfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  // completed frame results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [0] armed, [1] motor_enable, [4:2] height_mode,
                                  // [16:5] target_height, [19:17] flight_mode,
                                  // [23:20] zero
  output logic [1:0]  out_tuser   // [1:0] frame_type
);

  typedef enum logic [2:0] {
    ST_HUNT = 3'd0,
    ST_HDR1 = 3'd1,
    ST_TYPE = 3'd2,
    ST_SET  = 3'd3,
    ST_HGT  = 3'd4,
    ST_FLY  = 3'd5
  } state_t;

  // Input register
  logic       in_v_r;
  logic [7:0] in_byte_r;

  // Parser and command state
  state_t      state_r, state_nxt;
  logic        pcnt_r, pcnt_nxt;
  logic [7:0]  hcode_r;
  logic        hcode_load;
  logic        armed_r, armed_nxt;
  logic        motor_r, motor_nxt;
  logic [2:0]  hmode_r, hmode_nxt;
  logic [11:0] target_r, target_nxt;
  logic [2:0]  fmode_r, fmode_nxt;

  // Result register
  logic        out_v_r;
  logic [1:0]  out_kind_r;
  logic [19:0] out_data_r;

  logic        emit;
  logic [1:0]  kind;
  logic        adv;
  logic        fire;
  logic [11:0] times_ten;

  // Stage moves when the result slot is free or being drained this cycle
  assign adv       = !out_v_r || out_tready;
  assign fire      = in_v_r && adv;
  assign in_tready = !in_v_r || adv;

  // byte * 10 as (byte << 3) + (byte << 1)
  assign times_ten = {1'b0, in_byte_r, 3'b000} + {3'b000, in_byte_r, 1'b0};

  always_comb begin
    state_nxt  = state_r;
    pcnt_nxt   = pcnt_r;
    hcode_load = 1'b0;
    armed_nxt  = armed_r;
    motor_nxt  = motor_r;
    hmode_nxt  = hmode_r;
    target_nxt = target_r;
    fmode_nxt  = fmode_r;
    emit       = 1'b0;
    kind       = KIND_SET;
    case (state_r)
      ST_HUNT: begin
        state_nxt = (in_byte_r == HDR_FIRST) ? ST_HDR1 : ST_HUNT;
      end
      ST_HDR1: begin
        // failed byte is not retried as a first header byte
        state_nxt = (in_byte_r == HDR_SECOND) ? ST_TYPE : ST_HUNT;
      end
      ST_TYPE: begin
        if (in_byte_r == TYPE_SET) begin
          state_nxt = ST_SET;
        end else if (in_byte_r == TYPE_HGT) begin
          state_nxt = ST_HGT;
          pcnt_nxt  = 1'b0;
        end else if (in_byte_r == TYPE_FLY) begin
          state_nxt = ST_FLY;
        end else begin
          state_nxt = ST_HUNT;
        end
      end
      ST_SET: begin
        if (in_byte_r == SET_DISARM) begin
          armed_nxt = 1'b0;
        end else if (in_byte_r == SET_ARM) begin
          armed_nxt = 1'b1;
        end else if (in_byte_r == SET_MOTOR_OFF) begin
          motor_nxt = 1'b0;
        end
        state_nxt = ST_HUNT;
        emit      = 1'b1;
        kind      = KIND_SET;
      end
      ST_HGT: begin
        if (!pcnt_r) begin
          hcode_load = 1'b1;
          pcnt_nxt   = 1'b1;
        end else begin
          pcnt_nxt = 1'b0;
          case (hcode_r)
            HCMD_TARGET: begin
              hmode_nxt  = HMODE_TARGET;
              target_nxt = times_ten;
            end
            HCMD_MODE4: hmode_nxt = HMODE_4;
            HCMD_MODE3: hmode_nxt = HMODE_3;
            HCMD_MODE1: hmode_nxt = HMODE_1;
            default:    hmode_nxt = hmode_r;
          endcase
          state_nxt = ST_HUNT;
          emit      = 1'b1;
          kind      = KIND_HGT;
        end
      end
      ST_FLY: begin
        case (in_byte_r)
          FCMD_1:  fmode_nxt = FMODE_1;
          FCMD_2:  fmode_nxt = FMODE_2;
          FCMD_3:  fmode_nxt = FMODE_3;
          FCMD_4:  fmode_nxt = FMODE_4;
          FCMD_5:  fmode_nxt = FMODE_5;
          default: fmode_nxt = fmode_r;
        endcase
        state_nxt = ST_HUNT;
        emit      = 1'b1;
        kind      = KIND_FLY;
      end
      default: begin
        state_nxt = ST_HUNT;
      end
    endcase
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  // Parser state, command registers and result register; the result carries
  // the command registers after the update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_HUNT;
      pcnt_r   <= 1'b0;
      armed_r  <= 1'b0;
      motor_r  <= 1'b1;
      hmode_r  <= '0;
      target_r <= '0;
      fmode_r  <= '0;
      out_v_r  <= 1'b0;
    end else begin
      if (fire) begin
        state_r  <= state_nxt;
        pcnt_r   <= pcnt_nxt;
        armed_r  <= armed_nxt;
        motor_r  <= motor_nxt;
        hmode_r  <= hmode_nxt;
        target_r <= target_nxt;
        fmode_r  <= fmode_nxt;
      end
      if (adv) begin
        out_v_r <= fire && emit;
      end
    end
    // first height byte, always written before the second one reads it
    if (fire && hcode_load) begin
      hcode_r <= in_byte_r;
    end
    if (fire && emit) begin
      out_kind_r <= kind;
      out_data_r <= {fmode_nxt, target_nxt, hmode_nxt, motor_nxt, armed_nxt};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {4'b0000, out_data_r};

`ifndef SYNTHESIS
  // A completed payload byte that is consumed always lands in the result slot
  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && emit) |=> out_v_r)
    else $error("completed frame did not produce a result");

  // Second height byte is only expected inside a height payload
  a_pcnt_state: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r |-> (state_r == ST_HGT))
    else $error("payload count set outside height payload");

  // Target height stays at or below MAX_HEIGHT (2550 = 255 * 10)
  a_target_range: assert property (@(posedge clk) disable iff (!rst_n)
    target_r <= MAX_HEIGHT)
    else $error("target height out of range");

  // Reported frame kind is one of the three frame types
  a_kind_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_kind_r == KIND_SET || out_kind_r == KIND_HGT ||
                 out_kind_r == KIND_FLY))
    else $error("bad frame kind on result");
`endif

endmodule
